### hw/rtl/pis_pkg.sv
// Package for the packet impairment scheduler: sizes, codes, state machine
// type, controller/datapath structs and classification/rule tables. No deps.
package pis_pkg;

    localparam int NUM_QUEUES  = 10;
    localparam int QUEUE_DEPTH = 4096;
    localparam int HANDLE_BITS = 16;
    localparam int TIME_BITS   = 48;

    localparam int QW        = 4;
    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int OW        = PW + 1;
    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int CFG_W     = 16;
    localparam int DELAY_W   = 14;
    localparam int PROD_W    = DELAY_W + CFG_W;
    localparam int CNT_W     = 64;
    localparam int PATTERN_COUNT = 10;
    localparam int MIN_LEN   = 32;
    localparam logic [CFG_W-1:0] TPU_RESET = 16'd1000;

    typedef logic [QW-1:0]          t_qidx;
    typedef logic [HANDLE_BITS-1:0] t_handle;
    typedef logic [TIME_BITS-1:0]   t_time;

    typedef enum logic [2:0] {
        EV_RULE_DROP  = 3'd0,
        EV_QUEUED     = 3'd1,
        EV_DUP_QUEUED = 3'd2,
        EV_FULL_DROP  = 3'd3,
        EV_SENT       = 3'd4
    } t_event;

    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_STAMP, S_DROP, S_DUP, S_ORIG, S_SEL, S_SEND, S_FILL
    } t_state;

    typedef struct packed {
        logic load_in;
        logic classify;
        logic stamp;
        logic emit_drop;
        logic emit_dup;
        logic emit_orig;
        logic select;
        logic emit_send;
        logic fill;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic drop_hit;
        logic dup_hit;
        logic found;
        logic out_free;
        logic fill_needed;
    } t_status;

    function automatic t_qidx classify(input logic [7:0] dir, input logic [7:0] flow,
                                       input logic [13:0] len);
        logic [7:0] pf [PATTERN_COUNT];
        logic [7:0] pd [PATTERN_COUNT];
        t_qidx q;
        pf = '{8'h16, 8'h16, 8'h26, 8'h26, 8'h36, 8'h36, 8'h53, 8'h53, 8'h63, 8'h63};
        pd = '{8'hcd, 8'hcc, 8'hcd, 8'hcc, 8'hcd, 8'hcc, 8'hcd, 8'hcc, 8'hcd, 8'hcc};
        q = QW'(NUM_QUEUES - 1);
        if (len >= 14'(MIN_LEN)) begin
            for (int i = PATTERN_COUNT - 1; i >= 0; i--) begin
                if (i < NUM_QUEUES && pf[i] == flow && pd[i] == dir) begin
                    q = QW'(i);
                end
            end
        end
        return q;
    endfunction

    // r10 = count mod 10, r3 = count mod 3 (after the increment)
    function automatic logic rule_drop(input t_qidx q, input logic [3:0] r10);
        logic every5;
        every5 = (r10 == 4'd0) || (r10 == 4'd5);
        case (q)
            4'd1, 4'd7: return r10 == 4'd0;
            4'd2, 4'd8: return every5;
            default:    return 1'b0;
        endcase
    endfunction

    function automatic logic rule_dup(input t_qidx q, input logic [3:0] r10,
                                      input logic [1:0] r3);
        logic every5;
        every5 = (r10 == 4'd0) || (r10 == 4'd5);
        case (q)
            4'd3, 4'd7: return r10 == 4'd0;
            4'd4:       return r3 == 2'd0;
            4'd9:       return every5;
            default:    return 1'b0;
        endcase
    endfunction

    function automatic logic [DELAY_W-1:0] rule_delay(input t_qidx q);
        case (q)
            4'd5, 4'd8: return 14'd1000;
            4'd6, 4'd9: return 14'd10000;
            default:    return '0;
        endcase
    endfunction

endpackage

### hw/rtl/pis_if.sv
// Channel interfaces of the packet impairment scheduler.
// Depends on pis_pkg.
interface pis_in_if;
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [7:0]              direction_byte;
    logic [7:0]              flow_byte;
    logic [13:0]             packet_length;
    pis_pkg::t_handle        packet_handle;
    pis_pkg::t_time          now_time;
    modport source (output valid, kind, direction_byte, flow_byte, packet_length,
                    packet_handle, now_time, input ready);
    modport sink   (input valid, kind, direction_byte, flow_byte, packet_length,
                    packet_handle, now_time, output ready);
endinterface

interface pis_out_if;
    logic                    valid;
    logic                    ready;
    logic [2:0]              event_res;
    pis_pkg::t_qidx          queue_index;
    pis_pkg::t_handle        out_handle;
    pis_pkg::t_time          release_stamp;
    logic                    last;
    modport source (output valid, event_res, queue_index, out_handle, release_stamp,
                    last, input ready);
    modport sink   (input valid, event_res, queue_index, out_handle, release_stamp,
                    last, output ready);
endinterface

interface pis_cfg_if;
    logic                    valid;
    logic                    ready;
    logic [pis_pkg::CFG_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/pis_ctrl.sv
// Sequencer of the packet impairment scheduler.
// Depends on pis_pkg; drives commands into pis_dpath.
module pis_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pis_pkg::t_status  i_status,
    output pis_pkg::t_cmd     o_cmd
);
    import pis_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CLASS;
            S_CLASS: n_state = i_status.kind ? S_SEL : S_STAMP;
            S_STAMP: begin
                if (i_status.drop_hit)     n_state = S_DROP;
                else if (i_status.dup_hit) n_state = S_DUP;
                else                       n_state = S_ORIG;
            end
            S_DROP:  if (i_status.out_free) n_state = S_IDLE;
            S_DUP:   if (i_status.out_free) n_state = S_ORIG;
            S_ORIG:  if (i_status.out_free) n_state = S_IDLE;
            S_SEL:   n_state = i_status.found ? S_SEND : S_IDLE;
            S_SEND: begin
                if (i_status.out_free) n_state = i_status.fill_needed ? S_FILL : S_IDLE;
            end
            S_FILL:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            // tick items pass through here too: classify only acts on arrivals
            S_CLASS: o_cmd.classify  = !i_status.kind;
            S_STAMP: o_cmd.stamp     = 1'b1;
            S_DROP:  o_cmd.emit_drop = i_status.out_free;
            S_DUP:   o_cmd.emit_dup  = i_status.out_free;
            S_ORIG:  o_cmd.emit_orig = i_status.out_free;
            S_SEL:   o_cmd.select    = 1'b1;
            S_SEND:  o_cmd.emit_send = i_status.out_free;
            S_FILL:  o_cmd.fill      = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

### hw/rtl/pis_dpath.sv
// Datapath of the packet impairment scheduler: item registers, per-queue
// counters and head registers, queue memory, output register. Uses pis_pkg.
module pis_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pis_pkg::t_cmd        i_cmd,
    output pis_pkg::t_status     o_status,
    input  logic                 i_kind,
    input  logic [7:0]           i_direction_byte,
    input  logic [7:0]           i_flow_byte,
    input  logic [13:0]          i_packet_length,
    input  pis_pkg::t_handle     i_packet_handle,
    input  pis_pkg::t_time       i_now_time,
    input  logic                 i_cfg_valid,
    input  logic [pis_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [2:0]           o_event_res,
    output pis_pkg::t_qidx       o_queue_index,
    output pis_pkg::t_handle     o_out_handle,
    output pis_pkg::t_time       o_release_stamp,
    output logic                 o_last
);
    import pis_pkg::*;

    // item registers
    logic             r_kind;
    logic [7:0]       r_dir, r_flow;
    logic [13:0]      r_len;
    t_handle          r_handle;
    t_time            r_now;
    t_qidx            r_q;
    logic             r_drop, r_dup;
    logic [PROD_W-1:0] r_prod;
    t_time            r_stamp;
    logic [CFG_W-1:0] r_tpu;

    // per-queue state
    logic [PW-1:0]    r_rp    [NUM_QUEUES];
    logic [OW-1:0]    r_occ   [NUM_QUEUES];
    logic [CNT_W-1:0] r_cnt   [NUM_QUEUES];
    logic [3:0]       r_r10   [NUM_QUEUES];
    logic [1:0]       r_r3    [NUM_QUEUES];
    t_handle          r_head_h[NUM_QUEUES];
    t_time            r_head_t[NUM_QUEUES];

    t_qidx            r_best;

    logic [HANDLE_BITS+TIME_BITS-1:0] mem [MEM_DEPTH];
    logic [HANDLE_BITS+TIME_BITS-1:0] r_rd;

    logic             r_out_valid;
    t_event           r_ev;
    t_qidx            r_out_q;
    t_handle          r_out_h;
    t_time            r_out_t;
    logic             r_out_last;

    // classification of the held arrival
    t_qidx            c_q;
    logic [CNT_W-1:0] c_cnt;
    logic             c_wrap;
    logic [3:0]       c_r10;
    logic [1:0]       c_r3;

    always_comb begin
        c_q    = classify(r_dir, r_flow, r_len);
        c_cnt  = r_cnt[c_q];
        c_wrap = &c_cnt;
        c_r10  = (c_wrap || r_r10[c_q] == 4'd9) ? 4'd0 : r_r10[c_q] + 4'd1;
        c_r3   = (c_wrap || r_r3[c_q] == 2'd2) ? 2'd0 : r_r3[c_q] + 2'd1;
    end

    // push into r_q
    logic          p_full, p_en;
    logic [PW-1:0] p_slot;
    logic [AW-1:0] p_addr;

    always_comb begin
        p_full = r_occ[r_q] >= OW'(QUEUE_DEPTH - 1);
        p_en   = (i_cmd.emit_dup || i_cmd.emit_orig) && !p_full;
        p_slot = r_rp[r_q] + r_occ[r_q][PW-1:0];
        p_addr = AW'(r_q) * AW'(QUEUE_DEPTH) + AW'(p_slot);
    end

    // pop from r_best
    logic [PW-1:0] s_next;
    logic [AW-1:0] s_addr;

    always_comb begin
        s_next = r_rp[r_best] + PW'(1);
        s_addr = AW'(r_best) * AW'(QUEUE_DEPTH) + AW'(s_next);
    end

    // earliest due head, lowest queue on a tie
    t_qidx b_q;
    logic  b_found;
    t_time b_t;

    always_comb begin
        b_q     = '0;
        b_found = 1'b0;
        b_t     = '0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            if (r_occ[q] != '0 && r_head_t[q] <= r_now
                && (!b_found || r_head_t[q] < b_t)) begin
                b_found = 1'b1;
                b_q     = QW'(q);
                b_t     = r_head_t[q];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind   <= i_kind;
            r_dir    <= i_direction_byte;
            r_flow   <= i_flow_byte;
            r_len    <= i_packet_length;
            r_handle <= i_packet_handle;
            r_now    <= i_now_time;
        end
        if (i_cmd.classify) begin
            r_q    <= c_q;
            r_drop <= rule_drop(c_q, c_r10);
            r_dup  <= rule_dup(c_q, c_r10, c_r3);
            r_prod <= PROD_W'(rule_delay(c_q)) * PROD_W'(r_tpu);
        end
        if (i_cmd.stamp) begin
            r_stamp <= r_now + TIME_BITS'(r_prod);
        end
        if (i_cmd.select) begin
            r_best  <= b_q;
        end
    end

    // queue memory
    always_ff @(posedge i_clk) begin
        if (p_en) begin
            mem[p_addr] <= {r_handle, r_stamp};
        end
        if (i_cmd.emit_send) begin
            r_rd <= mem[s_addr];
        end
    end

    // head registers
    always_ff @(posedge i_clk) begin
        if (p_en && r_occ[r_q] == '0) begin
            r_head_h[r_q] <= r_handle;
            r_head_t[r_q] <= r_stamp;
        end
        if (i_cmd.fill) begin
            {r_head_h[r_best], r_head_t[r_best]} <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu <= TPU_RESET;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_rp[q]  <= '0;
                r_occ[q] <= '0;
                r_cnt[q] <= '0;
                r_r10[q] <= '0;
                r_r3[q]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_tpu <= i_cfg_data;
            end
            if (i_cmd.classify) begin
                r_cnt[c_q] <= c_cnt + CNT_W'(1);
                r_r10[c_q] <= c_r10;
                r_r3[c_q]  <= c_r3;
            end
            if (p_en) begin
                r_occ[r_q] <= r_occ[r_q] + OW'(1);
            end
            if (i_cmd.emit_send) begin
                r_rp[r_best]  <= s_next;
                r_occ[r_best] <= r_occ[r_best] - OW'(1);
            end
        end
    end

    // output register
    logic emit;
    assign emit = i_cmd.emit_drop || i_cmd.emit_dup || i_cmd.emit_orig || i_cmd.emit_send;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_q    <= i_cmd.emit_send ? r_best : r_q;
            r_out_h    <= i_cmd.emit_send ? r_head_h[r_best] : r_handle;
            r_out_t    <= i_cmd.emit_send ? r_head_t[r_best]
                        : (i_cmd.emit_drop ? '0 : r_stamp);
            r_out_last <= !i_cmd.emit_dup;
            if (i_cmd.emit_send)       r_ev <= EV_SENT;
            else if (i_cmd.emit_drop)  r_ev <= EV_RULE_DROP;
            else if (p_full)           r_ev <= EV_FULL_DROP;
            else if (i_cmd.emit_dup)   r_ev <= EV_DUP_QUEUED;
            else                       r_ev <= EV_QUEUED;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_res     = r_ev;
    assign o_queue_index   = r_out_q;
    assign o_out_handle    = r_out_h;
    assign o_release_stamp = r_out_t;
    assign o_last          = r_out_last;

    assign o_status.kind        = r_kind;
    assign o_status.drop_hit    = r_drop;
    assign o_status.dup_hit     = r_dup;
    assign o_status.found       = b_found;
    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_status.fill_needed = r_occ[r_best] > OW'(1);

endmodule

### hw/rtl/packet_impairment_scheduler.sv
// Packet impairment scheduler: classify, drop/duplicate/delay and release.
// Items are handled one at a time. A tick with nothing due ends after S_SEL; a
// duplicate adds the S_DUP state, and a head refill adds S_FILL for the queue
// memory's registered read port. An item also waits in its emit state while an
// earlier result is still held in the output register.
// Reset: synchronous active low; queues empty, counters zero, rate 1000.
module packet_impairment_scheduler (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pis_in_if.sink    i_in,
    pis_out_if.source o_out,
    pis_cfg_if.sink   i_cfg
);
    import pis_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Rate register is always writable; the host must write it only while no item is
    // in flight; the block does not enforce this. Queue memory contents are not
    // cleared; only data read from occupied slots is ever used.
    assign i_cfg.ready = 1'b1;

    // Sequencer: one item at a time, results leave through an output
    // register so the next item is taken while the last result waits.
    pis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: per-queue head registers feed the release search; the
    // queue memory is written on enqueue and read to refill a head.
    pis_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_kind           (i_in.kind),
        .i_direction_byte (i_in.direction_byte),
        .i_flow_byte      (i_in.flow_byte),
        .i_packet_length  (i_in.packet_length),
        .i_packet_handle  (i_in.packet_handle),
        .i_now_time       (i_in.now_time),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_event_res      (o_out.event_res),
        .o_queue_index    (o_out.queue_index),
        .o_out_handle     (o_out.out_handle),
        .o_release_stamp  (o_out.release_stamp),
        .o_last           (o_out.last)
    );

endmodule

### dv/pis_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the packet impairment scheduler: per-queue impairment predictor
// and the queue of expected results. Depends on pis_pkg.
class pis_scoreboard;
    typedef struct {
        pis_pkg::t_event ev;
        pis_pkg::t_qidx  q;
        pis_pkg::t_handle h;
        pis_pkg::t_time  stamp;
        logic            last;
    } t_result;

    typedef struct {
        pis_pkg::t_handle h;
        pis_pkg::t_time   stamp;
    } t_entry;

    t_result         pending[$];
    t_entry          fifo[pis_pkg::NUM_QUEUES][$];
    longint unsigned arrivals[pis_pkg::NUM_QUEUES];
    logic [15:0]     rate;
    int              errors;
    int              checked;
    int              sent_count;
    int              full_count;

    function new();
        rate = pis_pkg::TPU_RESET;
        errors = 0;
        checked = 0;
        sent_count = 0;
        full_count = 0;
        foreach (arrivals[i]) arrivals[i] = 0;
    endfunction

    function void set_rate(logic [15:0] v);
        rate = v;
    endfunction

    function int depth_of(int q);
        return fifo[q].size();
    endfunction

    // Pattern table: flow/direction pair to queue.
    function int queue_for(logic [7:0] dir, logic [7:0] flow, logic [13:0] len);
        logic [7:0] flows [10];
        flows = '{8'h16, 8'h16, 8'h26, 8'h26, 8'h36, 8'h36, 8'h53, 8'h53, 8'h63, 8'h63};
        if (len < 14'd32) return pis_pkg::NUM_QUEUES - 1;
        for (int i = 0; i < 10; i++)
            if (flows[i] == flow && dir == ((i % 2 == 0) ? 8'hcd : 8'hcc)) return i;
        return pis_pkg::NUM_QUEUES - 1;
    endfunction

    function logic enqueue(int q, pis_pkg::t_handle h, pis_pkg::t_time stamp);
        t_entry e;
        if (fifo[q].size() >= pis_pkg::QUEUE_DEPTH - 1) return 1'b0;
        e.h = h;
        e.stamp = stamp;
        fifo[q].push_back(e);
        return 1'b1;
    endfunction

    function void add(pis_pkg::t_event ev, int q, pis_pkg::t_handle h,
                      pis_pkg::t_time stamp, logic last);
        t_result r;
        r.ev = ev;
        r.q = pis_pkg::t_qidx'(q);
        r.h = h;
        r.stamp = stamp;
        r.last = last;
        pending.push_back(r);
    endfunction

    function void note_item(logic kind, logic [7:0] dir, logic [7:0] flow,
                            logic [13:0] len, pis_pkg::t_handle h, pis_pkg::t_time now);
        int q;
        int best;
        int drop_n;
        int dup_n;
        int delay_val;
        longint unsigned cnt;
        pis_pkg::t_time stamp;
        int drops [10];
        int dups [10];
        int delays [10];
        drops  = '{0, 10, 5, 0, 0, 0, 0, 10, 5, 0};
        dups   = '{0, 0, 0, 10, 3, 0, 0, 10, 0, 5};
        delays = '{0, 0, 0, 0, 0, 1000, 10000, 0, 1000, 10000};
        if (kind) begin
            best = -1;
            for (int i = 0; i < pis_pkg::NUM_QUEUES; i++) begin
                if (fifo[i].size() == 0) continue;
                if (fifo[i][0].stamp > now) continue;
                if (best < 0 || fifo[i][0].stamp < fifo[best][0].stamp) best = i;
            end
            if (best >= 0) begin
                add(pis_pkg::EV_SENT, best, fifo[best][0].h, fifo[best][0].stamp, 1'b1);
                void'(fifo[best].pop_front());
            end
            return;
        end
        q = queue_for(dir, flow, len);
        drop_n = drops[q];
        dup_n = dups[q];
        delay_val = delays[q];
        arrivals[q]++;
        cnt = arrivals[q];
        if (drop_n != 0 && cnt % drop_n == 0) begin
            add(pis_pkg::EV_RULE_DROP, q, h, '0, 1'b1);
            return;
        end
        stamp = now + pis_pkg::t_time'(delay_val * longint'(rate));
        if (dup_n != 0 && cnt % dup_n == 0)
            add(enqueue(q, h, stamp) ? pis_pkg::EV_DUP_QUEUED : pis_pkg::EV_FULL_DROP,
                q, h, stamp, 1'b0);
        add(enqueue(q, h, stamp) ? pis_pkg::EV_QUEUED : pis_pkg::EV_FULL_DROP,
            q, h, stamp, 1'b1);
    endfunction

    task check_result(logic [2:0] ev, pis_pkg::t_qidx q, pis_pkg::t_handle h,
                      pis_pkg::t_time stamp, logic last);
        t_result r;
        if (pending.size() == 0) begin
            report($sformatf("result with nothing pending: ev=%0d q=%0d h=%h", ev, q, h));
            return;
        end
        r = pending.pop_front();
        checked++;
        if (ev == pis_pkg::EV_SENT) sent_count++;
        if (ev == pis_pkg::EV_FULL_DROP) full_count++;
        if (ev !== r.ev || q !== r.q || h !== r.h || stamp !== r.stamp || last !== r.last)
            report($sformatf("got ev=%0d q=%0d h=%h t=%h l=%b, want ev=%0d q=%0d h=%h t=%h l=%b",
                             ev, q, h, stamp, last, r.ev, r.q, r.h, r.stamp, r.last));
    endtask

    task report(string msg);
        errors++;
        $display("MISMATCH: %s", msg);
    endtask
endclass

### dv/packet_impairment_scheduler_test.sv
`timescale 1ns / 1ps
// Testbench top for packet_impairment_scheduler: directed and random arrivals
// and ticks under varied back-pressure. Depends on pis_pkg, pis_if, pis_scoreboard.
module packet_impairment_scheduler_test;
    import pis_pkg::*;

    logic i_clk;
    logic i_rst_n;
    pis_in_if  in_ch();
    pis_out_if out_ch();
    pis_cfg_if cfg_ch();

    packet_impairment_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink),
        .o_out(out_ch.source), .i_cfg(cfg_ch.sink)
    );

    pis_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;
    int  cycle;
    int  accepted;
    logic [47:0] clock_now;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Timeout counter; generous for worst-case stalls.
    initial begin
        cycle = 0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (cycle > 900000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus an explicit long hold-off when requested.
    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.event_res, out_ch.queue_index, out_ch.out_handle,
                               out_ch.release_stamp, out_ch.last);
    end

    // Present one item after any random sender idling; return at the falling edge
    // after acceptance, leaving valid for the next caller to drive.
    task automatic send_item(logic kind, logic [7:0] dir, logic [7:0] flow,
                             logic [13:0] len, logic [15:0] h, logic [47:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.kind <= kind;
        in_ch.direction_byte <= dir;
        in_ch.flow_byte <= flow;
        in_ch.packet_length <= len;
        in_ch.packet_handle <= h;
        in_ch.now_time <= now;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_item(kind, dir, flow, len, h, now);
        accepted++;
        @(negedge i_clk);
    endtask

    // Wait until every expected result has arrived, then let the last item settle before touching config.
    task automatic wait_drained();
        in_ch.valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_rate(logic [15:0] v);
        cfg_ch.valid <= 1;
        cfg_ch.data <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        board.set_rate(v);
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    // Arrival mostly into a pattern queue, sometimes noise or short packets.
    task automatic random_arrival();
        int p;
        logic [7:0] flows [10];
        logic [7:0] dir;
        logic [7:0] flow;
        logic [13:0] len;
        flows = '{8'h16, 8'h16, 8'h26, 8'h26, 8'h36, 8'h36, 8'h53, 8'h53, 8'h63, 8'h63};
        p = $urandom_range(9);
        dir = (p % 2 == 0) ? 8'hcd : 8'hcc;
        flow = flows[p];
        len = 14'($urandom_range(16383, 32));
        case ($urandom_range(9))
            0: begin
                dir = 8'($urandom);
                flow = 8'($urandom);
            end
            1: len = 14'($urandom_range(31));
            default: ;
        endcase
        send_item(1'b0, dir, flow, len, 16'($urandom), clock_now);
    endtask

    // Timestamps advance slowly, with occasional jumps so delayed heads mature.
    task automatic random_item();
        if ($urandom_range(9) == 0) clock_now += 48'($urandom_range(20000000));
        else clock_now += 48'($urandom_range(3000));
        if ($urandom_range(1)) random_arrival();
        else send_item(1'b1, 8'($urandom), 8'($urandom), 14'($urandom), 16'($urandom),
                       clock_now);
    endtask

    task automatic phase(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) random_item();
    endtask

    task automatic flush_queues();
        for (int i = 0; i < 5000 && board.pending.size() + 1 > 0; i++) begin
            int total;
            total = 0;
            for (int q = 0; q < NUM_QUEUES; q++) total += board.depth_of(q);
            if (total == 0) break;
            send_item(1'b1, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF);
        end
    endtask

    initial begin
        board = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 0;
        accepted = 0;
        clock_now = 48'd5000;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.kind = 0;
        in_ch.direction_byte = 0;
        in_ch.flow_byte = 0;
        in_ch.packet_length = 0;
        in_ch.packet_handle = 0;
        in_ch.now_time = 0;
        cfg_ch.valid = 0;
        cfg_ch.data = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: tick on empty, every pattern, short packet, unmatched, extremes.
        send_item(1'b1, 8'hff, 8'hff, 14'h3fff, 16'hffff, 48'hFFFF_FFFF_FFFF);
        for (int p = 0; p < 10; p++) begin
            logic [7:0] flows [10];
            flows = '{8'h16, 8'h16, 8'h26, 8'h26, 8'h36, 8'h36, 8'h53, 8'h53, 8'h63, 8'h63};
            send_item(1'b0, (p % 2 == 0) ? 8'hcd : 8'hcc, flows[p], 14'd32, 16'(p), 48'd100);
        end
        send_item(1'b0, 8'hcd, 8'h16, 14'd31, 16'hffff, 48'hFFFF_FFFF_FF00);
        send_item(1'b0, 8'h00, 8'h00, 14'h3fff, 16'h0000, 48'd0);
        send_item(1'b0, 8'hcc, 8'h63, 14'h3fff, 16'h8000, 48'hFFFF_FFFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_item(1'b1, '0, '0, '0, '0, 48'd100);
        flush_queues();
        wait_drained();

        // Zero rate and maximum rate; time wrap happens near the top.
        write_rate(16'd0);
        send_item(1'b0, 8'hcc, 8'h36, 14'd64, 16'h1234, 48'hFFFF_FFFF_FFF0);
        send_item(1'b1, '0, '0, '0, '0, 48'hFFFF_FFFF_FFF0);
        wait_drained();
        write_rate(16'hffff);
        send_item(1'b0, 8'hcd, 8'h53, 14'd64, 16'h5678, 48'hFFFF_FFFF_FFF0);
        flush_queues();
        wait_drained();
        write_rate(16'd1);

        // Sender idles lightly, receiver heavily.
        phase(350, 19, 68);
        wait_drained();
        write_rate(16'd1000);

        // Long receiver hold-off while the sender keeps pushing.
        hold_cycles = 400;
        phase(120, 0, 0);
        wait_drained();

        // Receiver idles lightly, sender heavily.
        phase(350, 68, 19);
        // Pause until every expected result has arrived.
        wait_drained();
        write_rate(16'd37);
        phase(460, 0, 0);
        wait_drained();
        write_rate(16'd1000);

        repeat (100) @(negedge i_clk);
        $display("Covered %0d accepted items, %0d results (%0d sent, %0d full drops).",
                 accepted, board.checked, board.sent_count, board.full_count);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
